// ===== design/dhcpv6_option_scanner_defines.svh =====
// Assertion macros for the DHCPv6 option scanner.
// Included by the top level; depends on nothing else.
`ifndef DHCPV6_OPTION_SCANNER_DEFINES_SVH
`define DHCPV6_OPTION_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define DOS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dhcpv6_option_scanner: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define DOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dhcpv6_option_scanner: next-cycle check failed");

`endif

// ===== design/dos_pkg.sv =====
// Shared types and constants for the DHCPv6 option scanner.
// No dependencies; imported by every module of the block.
package dos_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned OFFSET_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_CODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd2;

	localparam logic [CFG_DATA_W-1:0] WINDOW_END_RESET = 16'hFFFF;
	localparam logic [OFFSET_W-1:0]   OFFSET_MAX       = 17'h1FFFF;

	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic [15:0] target_code;
		logic [15:0] window_start;
		logic [15:0] window_end;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic        status;
		logic [15:0] option_offset;
		logic [15:0] option_size;
		logic        run_end;
	} res_t;

endpackage

// ===== design/dos_cfg_regs.sv =====
// Configuration registers of the DHCPv6 option scanner.
// Depends on dos_pkg for register indexes and the cfg_t bundle.
module dos_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [dos_pkg::CFG_IDX_W-1:0]  index,
	input  logic [dos_pkg::CFG_DATA_W-1:0] wdata,
	output dos_pkg::cfg_t                  cfg
);
	import dos_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_code  <= '0;
			cfg_q.window_start <= '0;
			cfg_q.window_end   <= WINDOW_END_RESET;
		end else if (we) begin
			case (index)
				REG_TARGET_CODE:  cfg_q.target_code  <= wdata;
				REG_WINDOW_START: cfg_q.window_start <= wdata;
				REG_WINDOW_END:   cfg_q.window_end   <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/dos_walker.sv =====
// Input register and option-walk state of the DHCPv6 option scanner.
// Depends on dos_pkg; produces up to two results per byte for dos_out_buf.
module dos_walker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_data,
	input  logic          in_last,
	input  dos_pkg::cfg_t cfg,
	input  logic          load_ok,
	output logic          load,
	output dos_pkg::res_t res0,
	output dos_pkg::res_t res1,
	output logic [1:0]    res_cnt
);
	import dos_pkg::*;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_HEADER = 2'd1,
		PH_BODY   = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;

	logic [OFFSET_W-1:0] off_q, off_n;
	phase_t              phase_q, phase_n;
	logic [1:0]          hc_q, hc_n;
	logic [15:0]         code_q, code_n;
	logic [15:0]         len_q, len_n;
	logic [15:0]         begin_q, begin_n;
	logic [16:0]         limit_q, limit_n;
	logic                matched_q, matched_n;

	logic                advance;
	logic                match_v, done_v, done_st, bnd;
	logic [17:0]         p18, q18, w18, lim18;
	res_t                match_r, done_r;

	assign advance  = valid_s1 && load_ok;
	assign in_ready = !valid_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_data;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		off_n     = off_q;
		phase_n   = phase_q;
		hc_n      = hc_q;
		code_n    = code_q;
		len_n     = len_q;
		begin_n   = begin_q;
		limit_n   = limit_q;
		matched_n = matched_q;
		match_v   = 1'b0;
		done_v    = 1'b0;
		done_st   = STATUS_OK;
		bnd       = 1'b0;
		lim18     = '0;
		p18       = {1'b0, off_q};
		q18       = p18 + 18'd1;
		w18       = {2'b00, cfg.window_end};

		// enter the window
		if (phase_n == PH_SKIP && off_q >= {1'b0, cfg.window_start}) begin
			if (p18 >= w18) begin
				done_v  = 1'b1;
				phase_n = PH_DONE;
			end else if (p18 + 18'd4 > w18) begin
				done_v  = 1'b1;
				done_st = STATUS_ERR;
				phase_n = PH_DONE;
			end else begin
				phase_n = PH_HEADER;
				hc_n    = 2'd0;
				begin_n = off_q[15:0];
			end
		end

		// collect header, track body
		if (phase_n == PH_HEADER) begin
			if (!hc_n[1]) begin
				code_n = {code_n[7:0], byte_s1};
			end else begin
				len_n = {len_n[7:0], byte_s1};
			end
			if (hc_n == 2'd3) begin
				hc_n      = 2'd0;
				lim18     = {2'b00, begin_n} + 18'd4 + {2'b00, len_n};
				limit_n   = lim18[16:0];
				matched_n = (code_n == cfg.target_code);
				if (lim18 > w18) begin
					done_v  = 1'b1;
					done_st = STATUS_ERR;
					phase_n = PH_DONE;
				end else if (len_n == 16'd0) begin
					match_v = matched_n;
					bnd     = 1'b1;
				end else begin
					phase_n = PH_BODY;
				end
			end else begin
				hc_n = hc_n + 2'd1;
			end
		end else if (phase_n == PH_BODY) begin
			if (q18 >= {1'b0, limit_n}) begin
				match_v = matched_n;
				bnd     = 1'b1;
			end
		end

		match_r.kind          = KIND_MATCH;
		match_r.status        = STATUS_OK;
		match_r.option_offset = begin_n;
		match_r.option_size   = len_n + 16'd4;

		// option boundary or end of message
		if (bnd) begin
			if (last_s1 || q18 >= w18) begin
				done_v  = 1'b1;
				phase_n = PH_DONE;
			end else if (q18 + 18'd4 > w18) begin
				done_v  = 1'b1;
				done_st = STATUS_ERR;
				phase_n = PH_DONE;
			end else begin
				phase_n = PH_HEADER;
				hc_n    = 2'd0;
				begin_n = q18[15:0];
			end
		end else if (last_s1 && phase_n != PH_DONE) begin
			done_v  = 1'b1;
			done_st = (phase_n == PH_SKIP) ? STATUS_OK : STATUS_ERR;
			phase_n = PH_DONE;
		end

		match_r.run_end       = !done_v;

		done_r.kind          = KIND_DONE;
		done_r.status        = done_st;
		done_r.option_offset = '0;
		done_r.option_size   = '0;
		done_r.run_end       = 1'b1;

		if (match_v) begin
			res0    = match_r;
			res1    = done_r;
			res_cnt = done_v ? 2'd2 : 2'd1;
		end else begin
			res0    = done_r;
			res1    = done_r;
			res_cnt = done_v ? 2'd1 : 2'd0;
		end

		// rearm on the last byte
		if (last_s1) begin
			off_n     = '0;
			phase_n   = PH_SKIP;
			hc_n      = '0;
			code_n    = '0;
			len_n     = '0;
			begin_n   = '0;
			limit_n   = '0;
			matched_n = 1'b0;
		end else if (off_q != OFFSET_MAX) begin
			off_n = off_q + 1'b1;
		end
	end

	assign load = advance && (res_cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			phase_q   <= PH_SKIP;
			hc_q      <= '0;
			code_q    <= '0;
			len_q     <= '0;
			begin_q   <= '0;
			limit_q   <= '0;
			matched_q <= 1'b0;
		end else if (advance) begin
			off_q     <= off_n;
			phase_q   <= phase_n;
			hc_q      <= hc_n;
			code_q    <= code_n;
			len_q     <= len_n;
			begin_q   <= begin_n;
			limit_q   <= limit_n;
			matched_q <= matched_n;
		end
	end

endmodule

// ===== design/dos_out_buf.sv =====
// Two-entry result buffer of the DHCPv6 option scanner.
// Depends on dos_pkg for res_t; loaded by dos_walker, drained one beat a cycle while out_ready is high.
module dos_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  dos_pkg::res_t res0,
	input  dos_pkg::res_t res1,
	input  logic [1:0]    res_cnt,
	output logic          out_valid,
	input  logic          out_ready,
	output dos_pkg::res_t out_res,
	output logic          load_ok,
	output logic [1:0]    count
);
	import dos_pkg::*;

	logic [1:0] cnt_q;
	res_t       head_q;
	res_t       tail_q;
	logic       fire;

	assign out_valid = (cnt_q != 2'd0);
	assign fire      = out_valid && out_ready;
	assign load_ok   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && fire);
	assign out_res   = head_q;
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res_cnt;
		end else if (fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= res0;
			tail_q <= res1;
		end else if (fire) begin
			head_q <= tail_q;
		end
	end

endmodule

// ===== design/dhcpv6_option_scanner.sv =====
// DHCPv6 option scanner: walks options in a byte window and reports matches and a done beat.
// A byte's results pass through the input register and then the result buffer before they appear.
// Throughput: one byte per cycle while m_axis_tready is high; a byte causing a match and a done takes two output beats,
// so the input stalls while the two-entry result buffer drains.
// Reset: arst_n low clears the walk state, the buffers and the registers to their defaults.
// Depends on dos_pkg, dos_cfg_regs, dos_walker, dos_out_buf and the defines header.
`include "dhcpv6_option_scanner_defines.svh"

module dhcpv6_option_scanner (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [39:0]                    m_axis_tdata,  // [0] status, [16:1] option_offset,
	                                                      // [32:17] option_size, [39:33] zero
	output logic                           m_axis_tuser,  // [0] kind
	output logic                           m_axis_tlast,
	input  logic                           cfg_we,
	input  logic [dos_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dos_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import dos_pkg::*;

	cfg_t       cfg;
	res_t       res0, res1, out_res;
	logic [1:0] res_cnt, buf_count;
	logic       load, load_ok;

	dos_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	dos_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.cfg      (cfg),
		.load_ok  (load_ok),
		.load     (load),
		.res0     (res0),
		.res1     (res1),
		.res_cnt  (res_cnt)
	);

	dos_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res0      (res0),
		.res1      (res1),
		.res_cnt   (res_cnt),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res),
		.load_ok   (load_ok),
		.count     (buf_count)
	);

	assign m_axis_tdata = {7'd0, out_res.option_size, out_res.option_offset, out_res.status};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.run_end;

	`DOS_ASSERT_SAME(a_load_into_free_buf, clk, arst_n, load,
		(buf_count == 2'd0) || (buf_count == 2'd1 && m_axis_tvalid && m_axis_tready))
	`DOS_ASSERT_SAME(a_only_match_before_done, clk, arst_n, m_axis_tvalid && !m_axis_tlast,
		m_axis_tuser == KIND_MATCH)
	`DOS_ASSERT_NEXT(a_done_follows_match, clk, arst_n,
		m_axis_tvalid && m_axis_tready && !m_axis_tlast,
		m_axis_tvalid && m_axis_tuser == KIND_DONE)

endmodule
